// ===== rtl/qkc_pkg.sv =====
// qkc_pkg: shared types, codes and constants for the quadrature knob counter
// no dependencies; imported by every rtl module of the block
package qkc_pkg;

    localparam int VALUE_BITS  = 16;
    localparam int PERIOD_BITS = 16;
    localparam int CFG_BITS    = 16;
    localparam int FLAG_BITS   = 5;

    // reset values of the configuration registers
    localparam logic signed [VALUE_BITS-1:0] RELOAD_RESET = VALUE_BITS'(1024);
    localparam logic [PERIOD_BITS-1:0]       PERIOD_RESET = PERIOD_BITS'(10000);

    // configuration register indexes
    localparam logic REG_RELOAD_VALUE   = 1'b0;
    localparam logic REG_REFRESH_PERIOD = 1'b1;

    // encoder positions: bit 0 is channel a active, bit 1 channel b active
    localparam logic [1:0] POS_IDLE = 2'b00;
    localparam logic [1:0] POS_A    = 2'b01;
    localparam logic [1:0] POS_B    = 2'b10;
    localparam logic [1:0] POS_MID  = 2'b11;

    // edge flag bits
    localparam int FLAG_FIRST_A = 0;
    localparam int FLAG_FIRST_B = 1;
    localparam int FLAG_LAST_B  = 2;
    localparam int FLAG_LAST_A  = 3;
    localparam int FLAG_MID     = 4;

    // step event codes
    localparam logic [1:0] STEP_NONE = 2'd0;
    localparam logic [1:0] STEP_DOWN = 2'd1;
    localparam logic [1:0] STEP_UP   = 2'd2;

    typedef struct packed {
        logic [1:0]           last_pos;
        logic [FLAG_BITS-1:0] flags;
    } t_quad_state;

    typedef struct packed {
        logic [1:0]           step;
        t_quad_state          state;
    } t_quad_result;

endpackage

// ===== rtl/qkc_decoder.sv =====
// qkc_decoder: detent decoder, edge flag update and step decision for one sample
// depends on qkc_pkg
module qkc_decoder
    import qkc_pkg::*;
(
    input  logic         i_pin_a_level,
    input  logic         i_pin_b_level,
    input  t_quad_state  i_state,
    output t_quad_result o_result
);

    logic [1:0]           cur;
    logic [FLAG_BITS-1:0] f;
    logic [1:0]           step;

    always_comb begin
        cur  = {~i_pin_b_level, ~i_pin_a_level};
        f    = i_state.flags;
        step = STEP_NONE;
        if (cur != i_state.last_pos) begin
            if (i_state.last_pos == POS_IDLE) begin
                if (cur == POS_A) begin
                    f[FLAG_FIRST_A] = 1'b1;
                end else if (cur == POS_B) begin
                    f[FLAG_FIRST_B] = 1'b1;
                end
            end
            if (cur == POS_MID) begin
                f[FLAG_MID] = 1'b1;
            end else if (cur == POS_IDLE) begin
                if (i_state.last_pos == POS_B) begin
                    f[FLAG_LAST_B] = 1'b1;
                end else if (i_state.last_pos == POS_A) begin
                    f[FLAG_LAST_A] = 1'b1;
                end
                // detent complete: judge the collected edges
                priority if (f[FLAG_FIRST_A] && (f[FLAG_LAST_B] || f[FLAG_MID])) begin
                    step = STEP_DOWN;
                end else if (f[FLAG_LAST_B] && (f[FLAG_FIRST_A] || f[FLAG_MID])) begin
                    step = STEP_DOWN;
                end else if (f[FLAG_FIRST_B] && (f[FLAG_LAST_A] || f[FLAG_MID])) begin
                    step = STEP_UP;
                end else if (f[FLAG_LAST_A] && (f[FLAG_FIRST_B] || f[FLAG_MID])) begin
                    step = STEP_UP;
                end else begin
                    step = STEP_NONE;
                end
                f = '0;
            end
        end
        o_result.step           = step;
        o_result.state.last_pos = cur;
        o_result.state.flags    = f;
    end

endmodule

// ===== rtl/qkc_refresh_timer.sv =====
// qkc_refresh_timer: sample tick counter raising the display strobe
// depends on qkc_pkg
module qkc_refresh_timer
    import qkc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_tick,
    input  logic [PERIOD_BITS-1:0] i_period,
    output logic                   o_strobe
);

    logic [PERIOD_BITS-1:0] r_count;
    logic [PERIOD_BITS-1:0] n_count;
    logic [PERIOD_BITS:0]   count_inc;

    // 17 bit compare so a full period of 65535 still wraps correctly
    always_comb begin
        count_inc = {1'b0, r_count} + (PERIOD_BITS+1)'(1);
        o_strobe  = count_inc > {1'b0, i_period};
        n_count   = o_strobe ? '0 : count_inc[PERIOD_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_tick) begin
            r_count <= n_count;
        end
    end

endmodule

// ===== rtl/quadrature_knob_counter.sv =====
// quadrature_knob_counter: top level of the rotary knob decoder with reload switch
// depends on qkc_pkg, qkc_decoder, qkc_refresh_timer
//
// usage
// - input channel (i_in_valid / o_in_ready) carries one sample word per tick:
//   the two encoder pin levels and the push switch level, all active low
// - output channel (o_out_valid / i_out_ready) returns one result word per
//   sample: the value after the tick, the step event, the display strobe,
//   the value at the start of the tick and the switch press event
// - config port writes reload_value (index 0) or refresh_period (index 1)
//   whenever i_cfg_we is high; write only while no word is in flight
// timing
// - a sample is held in the input register until the output register is free
//   or draining, then the decoder, the refresh timer and the value update run
//   in a single pass into the output register, which raises o_out_valid
// - throughput one word per cycle while the output is not stalled; each word
//   updates the state of position, edge flags, value and tick count
// reset
// - synchronous active low; both register stages empty, position and flags
//   clear, value and reload register load 1024, period loads 10000
// stall
// - while i_out_ready is low the result holds; the input register still
//   takes one more word, then o_in_ready drops until the output drains
module quadrature_knob_counter
    import qkc_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // sample input channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_pin_a_level,
    input  logic                          i_pin_b_level,
    input  logic                          i_switch_level,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [VALUE_BITS-1:0]  o_count_value,
    output logic [1:0]                    o_step_event,
    output logic                          o_display_strobe,
    output logic signed [VALUE_BITS-1:0]  o_display_value,
    output logic                          o_switch_event,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [CFG_BITS-1:0]           i_cfg_data
);

    // configuration registers
    logic signed [VALUE_BITS-1:0] r_reload_value;
    logic [PERIOD_BITS-1:0]       r_refresh_period;

    // input register stage
    logic       r_in_valid;
    logic       r_pin_a;
    logic       r_pin_b;
    logic       r_switch;

    // decoder state
    t_quad_state                  r_quad;
    t_quad_result                 quad_next;
    logic                         r_switch_held;
    logic signed [VALUE_BITS-1:0] r_knob_value;
    logic signed [VALUE_BITS-1:0] n_knob_value;
    logic                         press;
    logic                         strobe;

    // output register stage
    logic                         r_out_valid;

    // a word moves from the input register into the output register
    logic advance;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reload_value   <= RELOAD_RESET;
            r_refresh_period <= PERIOD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_RELOAD_VALUE:   r_reload_value   <= VALUE_BITS'(i_cfg_data);
                REG_REFRESH_PERIOD: r_refresh_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input stage capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_pin_a  <= i_pin_a_level;
            r_pin_b  <= i_pin_b_level;
            r_switch <= i_switch_level;
        end
    end

    qkc_decoder u_decoder (
        .i_pin_a_level (r_pin_a),
        .i_pin_b_level (r_pin_b),
        .i_state       (r_quad),
        .o_result      (quad_next)
    );

    qkc_refresh_timer u_timer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (advance),
        .i_period (r_refresh_period),
        .o_strobe (strobe)
    );

    // step first, then a press edge overrides with the reload value
    always_comb begin
        press = !r_switch && !r_switch_held;
        unique case (quad_next.step)
            STEP_DOWN: n_knob_value = r_knob_value - VALUE_BITS'(1);
            STEP_UP:   n_knob_value = r_knob_value + VALUE_BITS'(1);
            default:   n_knob_value = r_knob_value;
        endcase
        if (press) begin
            n_knob_value = r_reload_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quad        <= '0;
            r_switch_held <= 1'b0;
            r_knob_value  <= RELOAD_RESET;
        end else if (advance) begin
            r_quad        <= quad_next.state;
            r_switch_held <= !r_switch;
            r_knob_value  <= n_knob_value;
        end
    end

    // output register stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            o_count_value    <= n_knob_value;
            o_step_event     <= quad_next.step;
            o_display_strobe <= strobe;
            o_display_value  <= r_knob_value;
            o_switch_event   <= press;
        end
    end

endmodule

// ===== rtl/qkc_checker.sv =====
// qkc_checker: port-level assertions for the quadrature knob counter
// depends on qkc_pkg; bound to quadrature_knob_counter below
module qkc_checker
    import qkc_pkg::*;
(
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic signed [VALUE_BITS-1:0] o_count_value,
    input logic [1:0]                   o_step_event,
    input logic signed [VALUE_BITS-1:0] o_display_value,
    input logic                         o_switch_event
);

    // a result word waits for the receiver
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result word dropped while stalled");

    a_step_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_step_event == STEP_NONE || o_step_event == STEP_DOWN ||
                         o_step_event == STEP_UP))
        else $error("undefined step event code");

    a_step_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_switch_event && o_step_event == STEP_UP
        |-> o_count_value == o_display_value + VALUE_BITS'(1))
        else $error("up step did not add one");

    a_step_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_switch_event && o_step_event == STEP_DOWN
        |-> o_count_value == o_display_value - VALUE_BITS'(1))
        else $error("down step did not subtract one");

    a_no_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_switch_event && o_step_event == STEP_NONE
        |-> o_count_value == o_display_value)
        else $error("value changed without step or press");

endmodule

bind quadrature_knob_counter qkc_checker u_qkc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_count_value   (o_count_value),
    .o_step_event    (o_step_event),
    .o_display_value (o_display_value),
    .o_switch_event  (o_switch_event)
);

// ===== verif/quadrature_knob_counter_tb.sv =====
// quadrature_knob_counter_tb: self-checking bench for the quadrature knob counter
// drives pin sample words through a valid/ready driver and checks every result word
// against a cycle-free model of the decoder; depends on qkc_pkg and the rtl top level
`timescale 1ns / 1ps

module quadrature_knob_counter_tb;
    import qkc_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int LIMIT_NS     = 20_000_000;  // watchdog time limit in ns
    localparam int LONG_HOLD    = 300;         // receiver hold-off in cycles
    localparam int PHASE_WORDS  = 130;
    localparam int REPORT_LIMIT = 10;

    // one sample word as offered on the input channel
    typedef struct packed {
        logic a_lvl;
        logic b_lvl;
        logic sw_lvl;
    } t_pin_sample;

    // one result word as seen on the output channel
    typedef struct packed {
        logic signed [VALUE_BITS-1:0] count;
        logic [1:0]                   step;
        logic                         strobe;
        logic signed [VALUE_BITS-1:0] shown;
        logic                         press;
    } t_knob_word;

    // clock, reset and block inputs, all known from time zero
    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                in_valid   = 1'b0;
    logic                pin_a      = 1'b1;
    logic                pin_b      = 1'b1;
    logic                sw_lvl     = 1'b1;
    logic                out_ready  = 1'b0;
    logic                cfg_we     = 1'b0;
    logic                cfg_index  = REG_RELOAD_VALUE;
    logic [CFG_BITS-1:0] cfg_data   = '0;

    logic                         o_in_ready;
    logic                         o_out_valid;
    logic signed [VALUE_BITS-1:0] o_count_value;
    logic [1:0]                   o_step_event;
    logic                         o_display_strobe;
    logic signed [VALUE_BITS-1:0] o_display_value;
    logic                         o_switch_event;

    // words waiting to be offered, and result words still owed by the block
    t_pin_sample pend_q[$];
    t_knob_word  owed_q[$];

    // decoder model state, mirrors the block after every accepted word
    logic [1:0]            m_pos     = POS_IDLE;
    logic [FLAG_BITS-1:0]  m_flags   = '0;
    logic                  m_sw_held = 1'b0;
    logic [VALUE_BITS-1:0] m_knob    = RELOAD_RESET;
    logic [PERIOD_BITS:0]  m_ticks   = '0;
    logic [CFG_BITS-1:0]   m_reload  = RELOAD_RESET;
    logic [PERIOD_BITS-1:0] m_period = PERIOD_RESET;

    // traffic shaping, changed by the stimulus only at the falling edge
    bit send_gaps  = 1'b1;
    int rx_mode    = 1;      // 0 always ready, 1 random stalls, 2 fixed pattern
    int press_pct  = 3;
    int stall_req  = 0;

    // stimulus-side switch generator and bookkeeping
    int sw_hold_left = 0;
    int queued_cnt   = 0;
    int write_cnt    = 0;
    int phase_cnt    = 0;

    // driver-side burst state
    int burst_left = 0;
    int gap_left   = 0;
    int taken_cnt  = 0;

    // receiver-side state
    int stall_seen = 0;
    int hold_left  = 0;
    int rx_tick    = 0;

    // checker tallies
    int err_cnt     = 0;
    int checked_cnt = 0;
    int down_cnt    = 0;
    int up_cnt      = 0;
    int press_cnt   = 0;
    int strobe_cnt  = 0;

    quadrature_knob_counter u_top (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (o_in_ready),
        .i_pin_a_level    (pin_a),
        .i_pin_b_level    (pin_b),
        .i_switch_level   (sw_lvl),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (out_ready),
        .o_count_value    (o_count_value),
        .o_step_event     (o_step_event),
        .o_display_strobe (o_display_strobe),
        .o_display_value  (o_display_value),
        .o_switch_event   (o_switch_event),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    always #(CLK_HALF) clk = ~clk;

    // one decoder tick: refresh timer, edge flags, detent step, switch reload
    function automatic t_knob_word advance_knob(input logic a_lvl, input logic b_lvl,
                                                input logic s_lvl);
        t_knob_word           r;
        logic [1:0]           cur;
        logic [FLAG_BITS-1:0] f;
        logic [PERIOD_BITS:0] nxt;
        r       = '0;
        r.shown = m_knob;
        // the tick count compares one bit wider than the period
        nxt = m_ticks + 1'b1;
        if (nxt > {1'b0, m_period}) begin
            r.strobe = 1'b1;
            m_ticks  = '0;
        end else begin
            m_ticks = nxt;
        end
        // pins are active low
        cur = {~b_lvl, ~a_lvl};
        if (cur != m_pos) begin
            f = m_flags;
            if (m_pos == POS_IDLE) begin
                if (cur == POS_A)
                    f[FLAG_FIRST_A] = 1'b1;
                else if (cur == POS_B)
                    f[FLAG_FIRST_B] = 1'b1;
            end
            if (cur == POS_MID) begin
                f[FLAG_MID] = 1'b1;
            end else if (cur == POS_IDLE) begin
                if (m_pos == POS_B)
                    f[FLAG_LAST_B] = 1'b1;
                else if (m_pos == POS_A)
                    f[FLAG_LAST_A] = 1'b1;
                // a sequence led by channel a counts down, one led by b counts up
                if (f[FLAG_FIRST_A] && (f[FLAG_LAST_B] || f[FLAG_MID]))
                    r.step = STEP_DOWN;
                else if (f[FLAG_LAST_B] && (f[FLAG_FIRST_A] || f[FLAG_MID]))
                    r.step = STEP_DOWN;
                else if (f[FLAG_FIRST_B] && (f[FLAG_LAST_A] || f[FLAG_MID]))
                    r.step = STEP_UP;
                else if (f[FLAG_LAST_A] && (f[FLAG_FIRST_B] || f[FLAG_MID]))
                    r.step = STEP_UP;
                f = '0;
            end
            m_flags = f;
        end
        m_pos = cur;
        if (r.step == STEP_DOWN)
            m_knob = m_knob - 1'b1;
        else if (r.step == STEP_UP)
            m_knob = m_knob + 1'b1;
        // press edge reloads and wins over a step in the same tick
        if (!s_lvl) begin
            if (!m_sw_held) begin
                m_knob  = VALUE_BITS'($signed(m_reload));
                r.press = 1'b1;
            end
            m_sw_held = 1'b1;
        end else begin
            m_sw_held = 1'b0;
        end
        r.count = m_knob;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // driver: offers pending words, in bursts when gaps are enabled, holds each until taken
    // ---------------------------------------------------------------
    always @(posedge clk) begin : drive_proc
        bit          fire;
        bit          go;
        t_pin_sample nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            fire = in_valid && o_in_ready;
            // the word on the pins right now was just taken: predict its result
            if (fire) begin
                owed_q.push_back(advance_knob(pin_a, pin_b, sw_lvl));
                taken_cnt++;
            end
            if (!(in_valid && !fire)) begin
                go = 1'b0;
                if (pend_q.size() != 0) begin
                    if (!send_gaps) begin
                        go = 1'b1;
                    end else if (gap_left != 0) begin
                        gap_left--;
                    end else begin
                        go = 1'b1;
                        if (burst_left == 0)
                            burst_left = $urandom_range(1, 12);
                        burst_left--;
                        if (burst_left == 0)
                            gap_left = $urandom_range(1, 6);
                    end
                end
                if (go) begin
                    nxt = pend_q.pop_front();
                    in_valid <= 1'b1;
                    pin_a    <= nxt.a_lvl;
                    pin_b    <= nxt.b_lvl;
                    sw_lvl   <= nxt.sw_lvl;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // receiver: stall pattern per phase, plus long hold-offs on request
    // ---------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (stall_seen != stall_req) begin
            // long hold so the block backs up into its input
            stall_seen++;
            hold_left = LONG_HOLD - 1;
            out_ready <= 1'b0;
        end else begin
            rx_tick++;
            case (rx_mode)
                0: begin
                    out_ready <= 1'b1;
                end
                1: begin
                    out_ready <= ($urandom_range(0, 99) >= 30);
                end
                default: begin
                    out_ready <= ((rx_tick % 7) < 4);
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // checker: every taken result word against the oldest owed one
    // ---------------------------------------------------------------
    always @(posedge clk) begin : check_proc
        t_knob_word want;
        if (o_out_valid && out_ready) begin
            if (owed_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= REPORT_LIMIT)
                    $display("unexpected result word: count %0d step %0d",
                             o_count_value, o_step_event);
            end else begin
                want = owed_q.pop_front();
                checked_cnt++;
                if (o_count_value !== want.count || o_step_event !== want.step ||
                    o_display_strobe !== want.strobe ||
                    o_display_value !== want.shown || o_switch_event !== want.press) begin
                    err_cnt++;
                    if (err_cnt <= REPORT_LIMIT)
                        $display({"mismatch on word %0d (expected/actual): count %0d/%0d ",
                                  "step %0d/%0d strobe %0b/%0b shown %0d/%0d press %0b/%0b"},
                                 checked_cnt, want.count, o_count_value, want.step,
                                 o_step_event, want.strobe, o_display_strobe, want.shown,
                                 o_display_value, want.press, o_switch_event);
                end
                if (want.step == STEP_DOWN)
                    down_cnt++;
                if (want.step == STEP_UP)
                    up_cnt++;
                if (want.press)
                    press_cnt++;
                if (want.strobe)
                    strobe_cnt++;
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers, all run from the stimulus process
    // ---------------------------------------------------------------
    task automatic queue_raw(input logic a_lvl, input logic b_lvl, input logic s_lvl);
        t_pin_sample w;
        w.a_lvl  = a_lvl;
        w.b_lvl  = b_lvl;
        w.sw_lvl = s_lvl;
        pend_q.push_back(w);
        queued_cnt++;
    endtask

    // random switch: short presses of one to four words
    task automatic queue_sample(input logic a_lvl, input logic b_lvl);
        if (sw_hold_left == 0 && $urandom_range(0, 99) < press_pct)
            sw_hold_left = $urandom_range(1, 4);
        queue_raw(a_lvl, b_lvl, sw_hold_left == 0);
        if (sw_hold_left != 0)
            sw_hold_left--;
    endtask

    // hold one encoder position for a few samples
    task automatic queue_pos(input logic [1:0] p);
        int reps;
        reps = $urandom_range(1, 3);
        repeat (reps) queue_sample(~p[0], ~p[1]);
    endtask

    // a full detent with random dwell on each position
    task automatic queue_detent(input bit up);
        if (up) begin
            queue_pos(POS_B);
            queue_pos(POS_MID);
            queue_pos(POS_A);
        end else begin
            queue_pos(POS_A);
            queue_pos(POS_MID);
            queue_pos(POS_B);
        end
        queue_pos(POS_IDLE);
    endtask

    // mostly clean detents, some bounces and broken sequences, a little noise
    task automatic queue_random_words(input int n_words);
        int start;
        int pick;
        int n;
        start = queued_cnt;
        while (queued_cnt - start < n_words) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                queue_detent($urandom_range(0, 1));
            end else if (pick < 88) begin
                n = $urandom_range(1, 3);
                repeat (n) queue_pos(2'($urandom));
                queue_pos(POS_IDLE);
            end else begin
                queue_sample(1'($urandom), 1'($urandom));
            end
        end
    endtask

    // block is idle: nothing pending, nothing on the pins, nothing owed
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pend_q.size() != 0 || in_valid || owed_q.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_knob_reg(input logic idx, input logic [CFG_BITS-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == REG_RELOAD_VALUE)
            m_reload = data;
        else
            m_period = data;
        write_cnt++;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // drain, then load both registers and the traffic shape for the next phase
    task automatic start_phase(input logic [CFG_BITS-1:0] reload, input logic [CFG_BITS-1:0] period,
                               input bit gaps, input int rx, input int pct);
        wait_drained();
        write_knob_reg(REG_RELOAD_VALUE, reload);
        write_knob_reg(REG_REFRESH_PERIOD, period);
        send_gaps = gaps;
        rx_mode   = rx;
        press_pct = pct;
        phase_cnt++;
    endtask

    // ---------------------------------------------------------------
    // stimulus: directed words, random phases, then the long period run
    // ---------------------------------------------------------------
    initial begin : stim_proc
        int k;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: reload 1024, period 10000
        queue_raw(1, 1, 1);
        // detent led by a counts down
        queue_raw(0, 1, 1); queue_raw(0, 0, 1); queue_raw(1, 0, 1); queue_raw(1, 1, 1);
        // detent led by b counts up
        queue_raw(1, 0, 1); queue_raw(0, 0, 1); queue_raw(0, 1, 1); queue_raw(1, 1, 1);
        // bounce on a alone is rejected
        queue_raw(0, 1, 1); queue_raw(1, 1, 1);
        // jump straight to the middle and back is rejected
        queue_raw(0, 0, 1); queue_raw(1, 1, 1);
        // press edge reloads, release
        queue_raw(1, 1, 0); queue_raw(1, 1, 1);
        // step and press in the same word: reload wins, step still reported
        queue_raw(0, 1, 1); queue_raw(0, 0, 1); queue_raw(1, 0, 1); queue_raw(1, 1, 0);

        // top reload and a strobe on every word; held switch does not reload again
        start_phase(16'h7fff, 16'd0, 1'b1, 1, 0);
        queue_raw(1, 1, 1); queue_raw(1, 1, 0);
        queue_raw(1, 0, 0); queue_raw(0, 0, 0); queue_raw(0, 1, 0); queue_raw(1, 1, 0);

        // bottom reload, wrap downward, strobe every second word
        start_phase(16'h8000, 16'd1, 1'b0, 2, 0);
        queue_raw(1, 1, 1); queue_raw(1, 1, 0);
        queue_raw(0, 1, 0); queue_raw(0, 0, 0); queue_raw(1, 0, 0); queue_raw(1, 1, 1);

        for (k = 0; k < 8; k++) begin
            case (k)
                0: start_phase(16'($urandom), 16'd100, 1'b1, 1, 3);
                // period lowered under the running count: next word strobes
                1: start_phase(16'($urandom), 16'd3, 1'b0, 2, 3);
                2: start_phase(16'd0, 16'd0, 1'b1, 0, 5);
                3: start_phase(16'($urandom), 16'($urandom_range(0, 15)), 1'b1, 1, 20);
                4: start_phase(16'h7fff, 16'd7, 1'b0, 1, 3);
                5: start_phase(16'h8000, 16'($urandom_range(0, 40)), 1'b1, 2, 3);
                6: start_phase(16'($urandom), 16'($urandom), 1'b1, 1, 8);
                default: start_phase(16'($urandom), 16'd2, 1'b0, 0, 3);
            endcase
            // receiver holds off while the sender keeps offering
            if (k == 1 || k == 4)
                stall_req++;
            queue_random_words(PHASE_WORDS);
        end

        // largest period: the wide compare must not strobe early, streamed back to back
        start_phase(16'($urandom), 16'hffff, 1'b0, 0, 2);
        queue_random_words(PHASE_WORDS);

        wait_drained();
        $display("run covered %0d sample words and %0d result words: %0d down, %0d up,",
                 taken_cnt, checked_cnt, down_cnt, up_cnt);
        $display("  %0d reloads, %0d strobes, %0d register writes over %0d phases",
                 press_cnt, strobe_cnt, write_cnt, phase_cnt + 1);
        if (err_cnt == 0 && owed_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatched or unexpected words", err_cnt);
            $display("Simulation FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(LIMIT_NS);
        $display("timeout with %0d words pending and %0d owed", pend_q.size(), owed_q.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
